// ===== src/tun_pkg.sv =====
// ----------------------------------------------------------------------------
// tun_pkg
// Widths, constants and stage payload types of the triangle unit normal core.
// ----------------------------------------------------------------------------
package tun_pkg;

	localparam int CoordW    = 32;
	localparam int EdgeW     = CoordW + 1;
	localparam int EMagW     = CoordW;
	localparam int ProdW     = 2 * EMagW;
	localparam int AccW      = ProdW + 2;
	localparam int MagW      = ProdW + 1;
	localparam int UW        = 31;
	localparam int SqW       = 2 * UW;
	localparam int SumW      = 64;
	localparam int LenW      = 32;
	localparam int LzW       = 7;
	localparam int ShW       = MagW + UW;
	localparam int ChunkW    = 8;
	localparam int Chunks    = (MagW + ChunkW - 1) / ChunkW;
	localparam int FracShift = 15;
	localparam int NumW      = UW + FracShift + 1;
	localparam int DenW      = LenW + 1;
	localparam int QW        = 15;
	localparam int OutW      = 16;
	localparam int SqStages  = 16;
	localparam int SqSteps   = SumW / 2 / SqStages;
	localparam int DivStages = 5;
	localparam int DivSteps  = QW / DivStages;

	localparam logic [QW-1:0]   QOne   = QW'(16384);
	localparam logic [OutW-1:0] Q14One = OutW'(16384);

	typedef struct packed {
		logic                   valid;
		logic [8:0][CoordW-1:0] v;
	} vtx_t;

	typedef struct packed {
		logic                 valid;
		logic [2:0]           neg;
		logic [2:0][MagW-1:0] mag;
	} cross_t;

	typedef struct packed {
		logic               valid;
		logic               degen;
		logic [2:0]         neg;
		logic [2:0][UW-1:0] u;
		logic [SumW-1:0]    sum;
	} scale_t;

	typedef struct packed {
		logic               valid;
		logic               degen;
		logic [2:0]         neg;
		logic [2:0][UW-1:0] u;
		logic [LenW-1:0]    len;
	} root_t;

	typedef struct packed {
		logic                 valid;
		logic                 degen;
		logic [2:0][OutW-1:0] n;
	} nrm_t;

endpackage

// ===== src/tun_vtx_if.sv =====
// ----------------------------------------------------------------------------
// tun_vtx_if
// Triangle vertex channel: valid, ready and nine Q16.16 coordinates.
// ----------------------------------------------------------------------------
interface tun_vtx_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] vertex0_x;
	logic signed [31:0] vertex0_y;
	logic signed [31:0] vertex0_z;
	logic signed [31:0] vertex1_x;
	logic signed [31:0] vertex1_y;
	logic signed [31:0] vertex1_z;
	logic signed [31:0] vertex2_x;
	logic signed [31:0] vertex2_y;
	logic signed [31:0] vertex2_z;

	modport source (
		output valid, vertex0_x, vertex0_y, vertex0_z, vertex1_x, vertex1_y, vertex1_z,
		       vertex2_x, vertex2_y, vertex2_z,
		input  ready
	);
	modport sink (
		input  valid, vertex0_x, vertex0_y, vertex0_z, vertex1_x, vertex1_y, vertex1_z,
		       vertex2_x, vertex2_y, vertex2_z,
		output ready
	);
endinterface

// ===== src/tun_nrm_if.sv =====
// ----------------------------------------------------------------------------
// tun_nrm_if
// Unit normal channel: valid, ready, three Q1.14 components and a flag.
// ----------------------------------------------------------------------------
interface tun_nrm_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] normal_x;
	logic signed [15:0] normal_y;
	logic signed [15:0] normal_z;
	logic               degenerate;

	modport source (output valid, normal_x, normal_y, normal_z, degenerate, input ready);
	modport sink (input valid, normal_x, normal_y, normal_z, degenerate, output ready);
endinterface

// ===== src/tun_cross.sv =====
// ----------------------------------------------------------------------------
// tun_cross
// Edge vectors and exact cross product as sign and magnitude, five stages.
// ----------------------------------------------------------------------------
module tun_cross (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  tun_pkg::vtx_t   in_d,
	output tun_pkg::cross_t out_d
);

	// edges 0..5 are e0x e0y e0z e1x e1y e1z; term i is e[TA]*e[TB] - e[TC]*e[TD]
	localparam int TA [3] = '{1, 2, 0};
	localparam int TB [3] = '{5, 3, 4};
	localparam int TC [3] = '{2, 0, 1};
	localparam int TD [3] = '{4, 5, 3};

	logic [5:0][tun_pkg::EdgeW-1:0]      diff_d, diff_s1;
	logic [5:0][tun_pkg::EMagW-1:0]      emag_d, emag_s2;
	logic [5:0]                          eneg_d, eneg_s2;
	logic [2:0][1:0][tun_pkg::ProdW-1:0] prod_d, prod_s3;
	logic [2:0][1:0]                     pneg_d, pneg_s3;
	logic [2:0][tun_pkg::AccW-1:0]       acc_d, acc_s4;
	logic [2:0]                          sgn_d, sgn_s4;
	logic [2:0][tun_pkg::MagW-1:0]       mag_d, mag_s5;
	logic [2:0]                          neg_d, neg_s5;
	logic                                valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;

	always_comb begin
		logic [tun_pkg::EdgeW-1:0] t;
		logic [tun_pkg::AccW-1:0]  n;
		for (int j = 0; j < 6; j++) begin
			diff_d[j] = {in_d.v[j+3][tun_pkg::CoordW-1], in_d.v[j+3]}
			          - {in_d.v[j%3][tun_pkg::CoordW-1], in_d.v[j%3]};
			eneg_d[j] = diff_s1[j][tun_pkg::EdgeW-1];
			t         = eneg_d[j] ? (tun_pkg::EdgeW'(0) - diff_s1[j]) : diff_s1[j];
			emag_d[j] = t[tun_pkg::EMagW-1:0];
		end
		for (int i = 0; i < 3; i++) begin
			prod_d[i][0] = emag_s2[TA[i]] * emag_s2[TB[i]];
			prod_d[i][1] = emag_s2[TC[i]] * emag_s2[TD[i]];
			pneg_d[i][0] = eneg_s2[TA[i]] ^ eneg_s2[TB[i]];
			pneg_d[i][1] = eneg_s2[TC[i]] ^ eneg_s2[TD[i]];
			// same product signs: difference of magnitudes, else their sum
			if (pneg_s3[i][0] == pneg_s3[i][1]) begin
				acc_d[i] = tun_pkg::AccW'(prod_s3[i][0]) - tun_pkg::AccW'(prod_s3[i][1]);
			end else begin
				acc_d[i] = tun_pkg::AccW'(prod_s3[i][0]) + tun_pkg::AccW'(prod_s3[i][1]);
			end
			sgn_d[i] = pneg_s3[i][0];
			n        = tun_pkg::AccW'(0) - acc_s4[i];
			if (acc_s4[i][tun_pkg::AccW-1]) begin
				mag_d[i] = n[tun_pkg::MagW-1:0];
				neg_d[i] = ~sgn_s4[i];
			end else begin
				mag_d[i] = acc_s4[i][tun_pkg::MagW-1:0];
				neg_d[i] = sgn_s4[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_d.valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			diff_s1 <= diff_d;
			emag_s2 <= emag_d;
			eneg_s2 <= eneg_d;
			prod_s3 <= prod_d;
			pneg_s3 <= pneg_d;
			acc_s4  <= acc_d;
			sgn_s4  <= sgn_d;
			mag_s5  <= mag_d;
			neg_s5  <= neg_d;
		end
	end

	assign out_d.valid = valid_s5;
	assign out_d.neg   = neg_s5;
	assign out_d.mag   = mag_s5;

endmodule

// ===== src/tun_scale.sv =====
// ----------------------------------------------------------------------------
// tun_scale
// Leading-one search, scaling to 31 bits, squares and their sum, five stages.
// ----------------------------------------------------------------------------
module tun_scale (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  tun_pkg::cross_t in_d,
	output tun_pkg::scale_t out_d
);

	localparam int PadW = tun_pkg::Chunks * tun_pkg::ChunkW;

	logic [tun_pkg::Chunks-1:0]          nz_d, nz_s6;
	logic [tun_pkg::Chunks-1:0][2:0]     pos_d, pos_s6;
	logic [2:0][tun_pkg::MagW-1:0]       mag_s6, mag_s7;
	logic [2:0]                          neg_s6, neg_s7, neg_s8, neg_s9, neg_s10;
	logic [tun_pkg::LzW-1:0]             lmax_d, lmax_s7;
	logic                                degen_s7, degen_s8, degen_s9, degen_s10;
	logic [2:0][tun_pkg::UW-1:0]         u_d, u_s8, u_s9, u_s10;
	logic [2:0][tun_pkg::SqW-1:0]        sq_d, sq_s9;
	logic [tun_pkg::SumW-1:0]            sum_d, sum_s10;
	logic                                valid_s6, valid_s7, valid_s8, valid_s9, valid_s10;

	always_comb begin
		logic [PadW-1:0]        orv;
		logic [tun_pkg::ShW-1:0] w;
		orv = PadW'(in_d.mag[0] | in_d.mag[1] | in_d.mag[2]);
		for (int c = 0; c < tun_pkg::Chunks; c++) begin
			nz_d[c]  = |orv[c*tun_pkg::ChunkW +: tun_pkg::ChunkW];
			pos_d[c] = 3'd0;
			for (int b = 0; b < tun_pkg::ChunkW; b++) begin
				if (orv[c*tun_pkg::ChunkW + b]) pos_d[c] = 3'(b);
			end
		end
		// bit length of the largest magnitude from the top nonzero chunk
		lmax_d = '0;
		for (int c = 0; c < tun_pkg::Chunks; c++) begin
			if (nz_s6[c]) begin
				lmax_d = tun_pkg::LzW'(c * tun_pkg::ChunkW) + tun_pkg::LzW'(pos_s6[c])
				       + tun_pkg::LzW'(1);
			end
		end
		for (int i = 0; i < 3; i++) begin
			w       = {mag_s7[i], {tun_pkg::UW{1'b0}}} >> lmax_s7;
			u_d[i]  = w[tun_pkg::UW-1:0];
			sq_d[i] = tun_pkg::SqW'(u_s8[i]) * tun_pkg::SqW'(u_s8[i]);
		end
		sum_d = tun_pkg::SumW'(sq_s9[0]) + tun_pkg::SumW'(sq_s9[1]) + tun_pkg::SumW'(sq_s9[2]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s6  <= 1'b0;
			valid_s7  <= 1'b0;
			valid_s8  <= 1'b0;
			valid_s9  <= 1'b0;
			valid_s10 <= 1'b0;
		end else if (en) begin
			valid_s6  <= in_d.valid;
			valid_s7  <= valid_s6;
			valid_s8  <= valid_s7;
			valid_s9  <= valid_s8;
			valid_s10 <= valid_s9;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nz_s6     <= nz_d;
			pos_s6    <= pos_d;
			mag_s6    <= in_d.mag;
			neg_s6    <= in_d.neg;
			mag_s7    <= mag_s6;
			neg_s7    <= neg_s6;
			lmax_s7   <= lmax_d;
			degen_s7  <= ~|nz_s6;
			u_s8      <= u_d;
			neg_s8    <= neg_s7;
			degen_s8  <= degen_s7;
			sq_s9     <= sq_d;
			u_s9      <= u_s8;
			neg_s9    <= neg_s8;
			degen_s9  <= degen_s8;
			sum_s10   <= sum_d;
			u_s10     <= u_s9;
			neg_s10   <= neg_s9;
			degen_s10 <= degen_s9;
		end
	end

	assign out_d.valid = valid_s10;
	assign out_d.degen = degen_s10;
	assign out_d.neg   = neg_s10;
	assign out_d.u     = u_s10;
	assign out_d.sum   = sum_s10;

endmodule

// ===== src/tun_sqrt.sv =====
// ----------------------------------------------------------------------------
// tun_sqrt
// Pipelined 64-bit integer square root, two result bits per stage.
// ----------------------------------------------------------------------------
module tun_sqrt (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  tun_pkg::scale_t in_d,
	output tun_pkg::root_t  out_d
);

	typedef struct packed {
		logic                        degen;
		logic [2:0]                  neg;
		logic [2:0][tun_pkg::UW-1:0] u;
		logic [tun_pkg::SumW-1:0]    rem;
		logic [tun_pkg::SumW-1:0]    res;
	} root_stage_t;

	root_stage_t                  root_d [tun_pkg::SqStages];
	root_stage_t                  root_s [tun_pkg::SqStages];
	logic [tun_pkg::SqStages-1:0] valid_s;

	function automatic root_stage_t root_step(input root_stage_t a, input int k);
		logic [tun_pkg::SumW-1:0] b;
		root_stage_t              r;
		b = tun_pkg::SumW'(1) << (tun_pkg::SumW - 2 - 2 * k);
		r = a;
		if (a.rem >= a.res + b) begin
			r.rem = a.rem - (a.res + b);
			r.res = (a.res >> 1) + b;
		end else begin
			r.res = a.res >> 1;
		end
		return r;
	endfunction

	always_comb begin
		root_stage_t src;
		for (int s = 0; s < tun_pkg::SqStages; s++) begin
			if (s == 0) begin
				src.degen = in_d.degen;
				src.neg   = in_d.neg;
				src.u     = in_d.u;
				src.rem   = in_d.sum;
				src.res   = '0;
			end else begin
				src = root_s[s-1];
			end
			for (int t = 0; t < tun_pkg::SqSteps; t++) begin
				src = root_step(src, s * tun_pkg::SqSteps + t);
			end
			root_d[s] = src;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= '0;
		end else if (en) begin
			valid_s <= {valid_s[tun_pkg::SqStages-2:0], in_d.valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int s = 0; s < tun_pkg::SqStages; s++) root_s[s] <= root_d[s];
		end
	end

	assign out_d.valid = valid_s[tun_pkg::SqStages-1];
	assign out_d.degen = root_s[tun_pkg::SqStages-1].degen;
	assign out_d.neg   = root_s[tun_pkg::SqStages-1].neg;
	assign out_d.u     = root_s[tun_pkg::SqStages-1].u;
	assign out_d.len   = root_s[tun_pkg::SqStages-1].res[tun_pkg::LenW-1:0];

endmodule

// ===== src/tun_div.sv =====
// ----------------------------------------------------------------------------
// tun_div
// Rounded division of each scaled component by the length, restoring and
// pipelined three quotient bits a stage, then sign and fallback selection.
// ----------------------------------------------------------------------------
module tun_div (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  tun_pkg::root_t in_d,
	output tun_pkg::nrm_t  out_d
);

	typedef struct packed {
		logic                          degen;
		logic [2:0]                    neg;
		logic [tun_pkg::DenW-1:0]      den;
		logic [2:0][tun_pkg::NumW-1:0] rem;
		logic [2:0][tun_pkg::QW-1:0]   q;
	} div_stage_t;

	div_stage_t                      div_d [tun_pkg::DivStages+1];
	div_stage_t                      div_s [tun_pkg::DivStages+1];
	logic [tun_pkg::DivStages:0]     valid_s;
	logic [2:0][tun_pkg::OutW-1:0]   n_d, n_q;
	logic                            degen_q, valid_q;

	always_comb begin
		div_stage_t               src;
		logic [tun_pkg::NumW-1:0] dsh;
		logic [tun_pkg::QW-1:0]   qc;
		int                       bi;
		// numerator u * 2^15 + len over 2 * len rounds half up
		div_d[0].degen = in_d.degen;
		div_d[0].neg   = in_d.neg;
		div_d[0].den   = {in_d.len, 1'b0};
		for (int i = 0; i < 3; i++) begin
			div_d[0].rem[i] = tun_pkg::NumW'({in_d.u[i], {tun_pkg::FracShift{1'b0}}})
			                + tun_pkg::NumW'(in_d.len);
			div_d[0].q[i]   = '0;
		end
		for (int s = 1; s <= tun_pkg::DivStages; s++) begin
			src = div_s[s-1];
			for (int t = 0; t < tun_pkg::DivSteps; t++) begin
				bi  = tun_pkg::QW - 1 - ((s - 1) * tun_pkg::DivSteps + t);
				dsh = tun_pkg::NumW'(src.den) << bi;
				for (int i = 0; i < 3; i++) begin
					if (src.rem[i] >= dsh) begin
						src.rem[i]  = src.rem[i] - dsh;
						src.q[i][bi] = 1'b1;
					end
				end
			end
			div_d[s] = src;
		end
		for (int i = 0; i < 3; i++) begin
			qc = div_s[tun_pkg::DivStages].q[i];
			if (qc > tun_pkg::QOne) qc = tun_pkg::QOne;
			if (div_s[tun_pkg::DivStages].neg[i]) begin
				n_d[i] = tun_pkg::OutW'(0) - tun_pkg::OutW'(qc);
			end else begin
				n_d[i] = tun_pkg::OutW'(qc);
			end
		end
		// degenerate triangle falls back to (0, 0, 1)
		if (div_s[tun_pkg::DivStages].degen) begin
			n_d[0] = '0;
			n_d[1] = '0;
			n_d[2] = tun_pkg::Q14One;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= '0;
			valid_q <= 1'b0;
		end else if (en) begin
			valid_s <= {valid_s[tun_pkg::DivStages-1:0], in_d.valid};
			valid_q <= valid_s[tun_pkg::DivStages];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int s = 0; s <= tun_pkg::DivStages; s++) div_s[s] <= div_d[s];
			n_q     <= n_d;
			degen_q <= div_s[tun_pkg::DivStages].degen;
		end
	end

	assign out_d.valid = valid_q;
	assign out_d.degen = degen_q;
	assign out_d.n     = n_q;

endmodule

// ===== src/triangle_unit_normal_core.sv =====
// ----------------------------------------------------------------------------
// triangle_unit_normal_core
// Unit face normal of a Q16.16 triangle in Q1.14, with a degenerate flag.
// ----------------------------------------------------------------------------
//  channel    role    payload
//  vertices   sink    vertex0..2 x/y/z, signed Q16.16
//  normal     source  normal_x/y/z signed Q1.14, degenerate
//
//  one triangle per cycle while the output is not stalled; a triangle passes
//  5 cross product, 5 scaling, 16 square root, 7 division and output stages
//  the square root chain of 16 stages is the longest part of the pipeline
//  reset clears only the valid bits; the data registers are not reset
//  a stalled output freezes every stage together, so nothing is lost or repeated
// ----------------------------------------------------------------------------
module triangle_unit_normal_core (
	input  logic clk,
	input  logic arst_n,
	tun_vtx_if.sink   vertices,
	tun_nrm_if.source normal
);

	tun_pkg::vtx_t   vtx;
	tun_pkg::cross_t crs;
	tun_pkg::scale_t scl;
	tun_pkg::root_t  rt;
	tun_pkg::nrm_t   nrm;
	logic            en;

	assign en             = ~nrm.valid | normal.ready;
	assign vertices.ready = en;

	assign vtx.valid = vertices.valid;
	assign vtx.v     = {vertices.vertex2_z, vertices.vertex2_y, vertices.vertex2_x,
	                    vertices.vertex1_z, vertices.vertex1_y, vertices.vertex1_x,
	                    vertices.vertex0_z, vertices.vertex0_y, vertices.vertex0_x};

	tun_cross u_cross (.clk(clk), .arst_n(arst_n), .en(en), .in_d(vtx), .out_d(crs));
	tun_scale u_scale (.clk(clk), .arst_n(arst_n), .en(en), .in_d(crs), .out_d(scl));
	tun_sqrt  u_sqrt  (.clk(clk), .arst_n(arst_n), .en(en), .in_d(scl), .out_d(rt));
	tun_div   u_div   (.clk(clk), .arst_n(arst_n), .en(en), .in_d(rt),  .out_d(nrm));

	assign normal.valid      = nrm.valid;
	assign normal.normal_x   = nrm.n[0];
	assign normal.normal_y   = nrm.n[1];
	assign normal.normal_z   = nrm.n[2];
	assign normal.degenerate = nrm.degen;

	a_fallback: assert property (@(posedge clk) disable iff (!arst_n)
		normal.valid && normal.degenerate |->
			normal.normal_x == 16'sd0 && normal.normal_y == 16'sd0 &&
			normal.normal_z == 16'sd16384)
		else $error("fallback normal wrong");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		normal.valid |->
			normal.normal_x >= -16'sd16384 && normal.normal_x <= 16'sd16384 &&
			normal.normal_y >= -16'sd16384 && normal.normal_y <= 16'sd16384 &&
			normal.normal_z >= -16'sd16384 && normal.normal_z <= 16'sd16384)
		else $error("normal component out of range");

	a_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		normal.valid && !normal.degenerate |->
			normal.normal_x != 16'sd0 || normal.normal_y != 16'sd0 ||
			normal.normal_z != 16'sd0)
		else $error("zero normal on a proper triangle");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		normal.valid && !normal.ready |=>
			normal.valid && $stable(nrm.n) && $stable(nrm.degen))
		else $error("result changed during stall");

endmodule
